/* rtl/ngh_pkg.sv */
// Shared types, constants and arithmetic helpers for the n-gram hash histogram.
package ngh_pkg;

   localparam int MaxBuckets  = 16384;
   localparam int MaxGram     = 6;
   localparam int MaxDocBytes = 1048576;

   localparam int BucketW = 14;
   localparam int CountW  = 23;
   localparam int NbW     = 15;
   localparam int SeenW   = 21;
   localparam int WinW    = 8 * MaxGram;

   localparam logic [CountW-1:0] CountMax     = '1;
   localparam logic [NbW-1:0]    BucketReset  = 15'd10000;
   localparam logic [5:0]        EnableReset  = 6'h3f;
   localparam logic [31:0]       CrcPoly      = 32'hEDB88320;
   localparam logic [SeenW-1:0]  DocLimit     = 21'(MaxDocBytes);

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_PUSH  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic {
      REG_BUCKET_COUNT = 1'b0,
      REG_SIZE_ENABLE  = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_RD,
      ST_WR,
      ST_RSP
   } state_type;

   typedef logic [BucketW-1:0] bucket_type;

   typedef struct packed {
      logic                 start;
      logic [WinW-1:0]      window;
      logic [MaxGram-1:0]   mask;
      logic [NbW-1:0]       nb;
   } hash_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [MaxGram-1:0]   mask;
   } hash_sts_type;

   // One byte of the reflected CRC-32.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   // One restoring remainder step: shift in a dividend bit, subtract if it fits.
   function automatic logic [BucketW-1:0] mod_step(input logic [BucketW-1:0] r,
                                                   input logic bitv,
                                                   input logic [NbW-1:0] nb);
      logic [NbW-1:0] t;
      t = {r, bitv};
      if (t >= nb) begin
         t = t - nb;
      end
      return t[BucketW-1:0];
   endfunction

endpackage

/* rtl/ngh_hist_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ngh_hist_ram #(
   parameter int ADDR_W = 14,
   parameter int DATA_W = 23
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/ngh_hash_unit.sv */
// Six CRC-32 lanes, one per n-gram length, each followed by a bucket remainder.
module ngh_hash_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  ngh_pkg::hash_cmd_type cmd,
   output ngh_pkg::hash_sts_type sts,
   output ngh_pkg::bucket_type   bucket [ngh_pkg::MaxGram]
);

   localparam int G = ngh_pkg::MaxGram;
   localparam logic [3:0] StepLoad = 4'd6;
   localparam logic [3:0] StepLast = 4'd14;

   logic [3:0]                  step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [ngh_pkg::WinW-1:0]    win_ff;
   logic [G-1:0]                mask_ff;
   logic [ngh_pkg::NbW-1:0]     nb_ff;
   logic [G-1:0]                stop_ff, stop_in;
   logic [31:0]                 crc_ff [G];
   logic [31:0]                 crc_in [G];
   logic [31:0]                 div_ff [G];
   logic [31:0]                 div_in [G];
   ngh_pkg::bucket_type         rem_ff [G];
   ngh_pkg::bucket_type         rem_in [G];

   always_comb begin
      logic [2:0]                  idx;
      logic [7:0]                  b;
      ngh_pkg::bucket_type         r;
      idx     = '0;
      b       = '0;
      r       = '0;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      stop_in = stop_ff;
      for (int k = 0; k < G; k++) begin
         crc_in[k] = crc_ff[k];
         div_in[k] = div_ff[k];
         rem_in[k] = rem_ff[k];
      end
      if (cmd.start) begin
         step_in = '0;
         busy_in = 1'b1;
         stop_in = '0;
         for (int k = 0; k < G; k++) begin
            crc_in[k] = '1;
         end
      end else if (busy_ff) begin
         step_in = step_ff + 4'd1;
         if (step_ff < StepLoad) begin
            // Lane k hashes the bytes from the oldest of its gram toward the newest.
            for (int k = 0; k < G; k++) begin
               idx = 3'(k) - step_ff[2:0];
               b   = win_ff[{idx, 3'b000} +: 8];
               if ({1'b0, step_ff[2:0]} <= 4'(k) && !stop_ff[k]) begin
                  if (b == 8'd0) begin
                     stop_in[k] = 1'b1;
                  end else begin
                     crc_in[k] = ngh_pkg::crc_byte(crc_ff[k], b);
                  end
               end
            end
         end else if (step_ff == StepLoad) begin
            for (int k = 0; k < G; k++) begin
               div_in[k] = ~crc_ff[k];
               rem_in[k] = '0;
            end
         end else begin
            // Four remainder bits per cycle, most significant first.
            for (int k = 0; k < G; k++) begin
               r = rem_ff[k];
               for (int i = 0; i < 4; i++) begin
                  r = ngh_pkg::mod_step(r, div_ff[k][31-i], nb_ff);
               end
               rem_in[k] = r;
               div_in[k] = div_ff[k] << 4;
            end
            if (step_ff == StepLast) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      stop_ff <= stop_in;
      if (cmd.start) begin
         win_ff  <= cmd.window;
         mask_ff <= cmd.mask;
         nb_ff   <= cmd.nb;
      end
      for (int k = 0; k < G; k++) begin
         crc_ff[k] <= crc_in[k];
         div_ff[k] <= div_in[k];
         rem_ff[k] <= rem_in[k];
      end
   end

   assign sts = '{done: done_ff, mask: mask_ff};

   always_comb begin
      for (int k = 0; k < G; k++) begin
         bucket[k] = rem_ff[k];
      end
   end

endmodule

/* rtl/ngram_crc_hash_histogram_top.sv */
// Top level: byte window, control sequencer and histogram memory of the n-gram hasher.
// A push holds req_tready low through hashing, one ST_RD step per gram length and one ST_WR
// step per enabled length; a read answers through the RAM read register and the response
// register; an ignored push or unused mode is accepted and dropped. Clearing sweeps all
// 16384 entries one per cycle after a clear or reset, with req_tready low throughout.
// Throughput is set by the CRC lanes, the 4-bit-per-cycle remainder and the single RAM.
module ngram_crc_hash_histogram_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte[7:0], bucket_index[21:8], zero fill
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // bucket_echo[13:0], frequency[36:14], zero fill
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [14:0] csr_wdata
);

   localparam int G = ngh_pkg::MaxGram;

   ngh_pkg::state_type          state_ff, state_in;
   logic [ngh_pkg::NbW-1:0]     bucket_count_ff;
   logic [5:0]                  size_enable_ff;
   logic [ngh_pkg::WinW-1:0]    window_ff, window_in;
   logic [ngh_pkg::SeenW-1:0]   seen_ff, seen_in;
   logic [ngh_pkg::BucketW-1:0] clr_ff, clr_in;
   logic [2:0]                  lane_ff, lane_in;
   logic                        in_range_ff, in_range_in;
   logic [ngh_pkg::BucketW-1:0] echo_ff, echo_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ngh_pkg::BucketW-1:0] rsp_echo_ff, rsp_echo_in;
   logic [ngh_pkg::CountW-1:0]  rsp_freq_ff, rsp_freq_in;

   logic [1:0]                  req_mode;
   logic [7:0]                  req_byte;
   logic [ngh_pkg::BucketW-1:0] req_index;
   logic [ngh_pkg::NbW-1:0]     nb;
   logic [ngh_pkg::SeenW-1:0]   seen_next;
   logic [G-1:0]                len_mask;

   ngh_pkg::hash_cmd_type       hcmd;
   ngh_pkg::hash_sts_type       hsts;
   ngh_pkg::bucket_type         hbucket [G];

   logic                        ram_we, ram_re;
   logic [ngh_pkg::BucketW-1:0] ram_waddr, ram_raddr;
   logic [ngh_pkg::CountW-1:0]  ram_wdata, ram_rdata;

   assign req_mode  = req_tuser;
   assign req_byte  = req_tdata[7:0];
   assign req_index = req_tdata[21:8];

   // A zero bucket count acts as one, and anything above the memory depth as the depth.
   always_comb begin
      if (bucket_count_ff == '0) begin
         nb = ngh_pkg::NbW'(1);
      end else if (bucket_count_ff > ngh_pkg::NbW'(ngh_pkg::MaxBuckets)) begin
         nb = ngh_pkg::NbW'(ngh_pkg::MaxBuckets);
      end else begin
         nb = bucket_count_ff;
      end
   end

   assign seen_next = seen_ff + ngh_pkg::SeenW'(1);

   always_comb begin
      for (int k = 0; k < G; k++) begin
         len_mask[k] = seen_next > ngh_pkg::SeenW'(k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= ngh_pkg::BucketReset;
         size_enable_ff  <= ngh_pkg::EnableReset;
      end else if (csr_we) begin
         unique case (ngh_pkg::reg_index_type'(csr_index))
            ngh_pkg::REG_BUCKET_COUNT: bucket_count_ff <= csr_wdata;
            ngh_pkg::REG_SIZE_ENABLE:  size_enable_ff  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      seen_in      = seen_ff;
      clr_in       = clr_ff;
      lane_in      = lane_ff;
      in_range_in  = in_range_ff;
      echo_in      = echo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_echo_in  = rsp_echo_ff;
      rsp_freq_in  = rsp_freq_ff;
      req_tready   = 1'b0;
      hcmd.start   = 1'b0;
      hcmd.window  = window_ff;
      hcmd.mask    = size_enable_ff & len_mask;
      hcmd.nb      = nb;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = req_index;
      unique case (state_ff)
         ngh_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + ngh_pkg::BucketW'(1);
            if (clr_ff == '1) begin
               state_in = ngh_pkg::ST_IDLE;
            end
         end
         ngh_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (ngh_pkg::mode_type'(req_mode))
                  ngh_pkg::MODE_CLEAR: begin
                     window_in = '0;
                     seen_in   = '0;
                     clr_in    = '0;
                     state_in  = ngh_pkg::ST_CLEAR;
                  end
                  ngh_pkg::MODE_PUSH: begin
                     if (seen_ff < ngh_pkg::DocLimit) begin
                        window_in   = {window_ff[ngh_pkg::WinW-9:0], req_byte};
                        seen_in     = seen_next;
                        hcmd.start  = 1'b1;
                        hcmd.window = {window_ff[ngh_pkg::WinW-9:0], req_byte};
                        state_in    = ngh_pkg::ST_HASH;
                     end
                  end
                  ngh_pkg::MODE_READ: begin
                     echo_in     = req_index;
                     in_range_in = {1'b0, req_index} < nb;
                     ram_re      = 1'b1;
                     state_in    = ngh_pkg::ST_RSP;
                  end
                  default: ;
               endcase
            end
         end
         ngh_pkg::ST_HASH: begin
            lane_in = '0;
            if (hsts.done) begin
               state_in = ngh_pkg::ST_RD;
            end
         end
         ngh_pkg::ST_RD: begin
            // Each bucket update reads, then writes, before the next lane reads.
            ram_raddr = hbucket[lane_ff];
            if (hsts.mask[lane_ff]) begin
               ram_re   = 1'b1;
               state_in = ngh_pkg::ST_WR;
            end else if (lane_ff == 3'(G - 1)) begin
               state_in = ngh_pkg::ST_IDLE;
            end else begin
               lane_in = lane_ff + 3'd1;
            end
         end
         ngh_pkg::ST_WR: begin
            ram_we    = 1'b1;
            ram_waddr = hbucket[lane_ff];
            ram_wdata = (ram_rdata == ngh_pkg::CountMax) ? ram_rdata
                                                          : ram_rdata + ngh_pkg::CountW'(1);
            if (lane_ff == 3'(G - 1)) begin
               state_in = ngh_pkg::ST_IDLE;
            end else begin
               lane_in  = lane_ff + 3'd1;
               state_in = ngh_pkg::ST_RD;
            end
         end
         ngh_pkg::ST_RSP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_echo_in  = echo_ff;
               rsp_freq_in  = in_range_ff ? ram_rdata : '0;
               state_in     = ngh_pkg::ST_IDLE;
            end
         end
         default: state_in = ngh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ngh_pkg::ST_CLEAR;
         window_ff    <= '0;
         seen_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         seen_ff      <= seen_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lane_ff     <= lane_in;
      in_range_ff <= in_range_in;
      echo_ff     <= echo_in;
      rsp_echo_ff <= rsp_echo_in;
      rsp_freq_ff <= rsp_freq_in;
   end

   ngh_hash_unit u_hash (
      .clock  (clock),
      .reset  (reset),
      .cmd    (hcmd),
      .sts    (hsts),
      .bucket (hbucket)
   );

   ngh_hist_ram #(
      .ADDR_W (ngh_pkg::BucketW),
      .DATA_W (ngh_pkg::CountW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_freq_ff, rsp_echo_ff};

endmodule

/* rtl/ngh_checker.sv */
// Port-level checks for the n-gram hash histogram, bound to the top level.
module ngh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The histogram is being swept right after reset.
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("ready during clearing after reset");

   // A clear transaction starts the sweep at once.
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ngh_pkg::MODE_CLEAR |=> !req_tready)
      else $error("ready right after a clear");

   // A new result answers a read transaction by way of ST_RSP and echoes its index.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         $past(req_tvalid && req_tready && req_tuser == ngh_pkg::MODE_READ, 2) &&
         rsp_tdata[13:0] == $past(req_tdata[21:8], 2))
      else $error("result without a matching read");

endmodule

bind ngram_crc_hash_histogram_top ngh_checker u_ngh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
